>>> rtl/dss_pkg.sv
package dss_pkg;

    // Default capacity of the shared array, in 32-bit words
    localparam int DEPTH_DEF = 16;

    localparam int DATA_W = 32;

    // Operation codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Result control that travels with a beat until the output register
    typedef struct packed {
        logic       use_mem;   // value comes from the array read port
        logic [1:0] status;
    } dss_ctl_t;

endpackage

>>> rtl/dss_ctrl.sv
module dss_ctrl #(
    parameter int DEPTH = dss_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          action,
    input  logic                stack_select,
    output logic                wr_en,
    output logic                rd_en,
    output logic [AW-1:0]       addr,
    output dss_pkg::dss_ctl_t   ctl
);
    import dss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [CW-1:0] lower_count_reg, lower_count_next;
    logic [CW-1:0] upper_count_reg, upper_count_next;
    logic [CW:0]   total;
    logic          full;
    logic          empty;
    logic [CW-1:0] lower_top;
    logic [CW-1:0] upper_push;
    logic [CW-1:0] upper_top;

    assign total      = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full       = (total >= {1'b0, DEPTH_C});
    assign empty      = stack_select ? (upper_count_reg == '0) : (lower_count_reg == '0);
    assign lower_top  = lower_count_reg - ONE_C;
    assign upper_top  = DEPTH_C - upper_count_reg;
    assign upper_push = upper_top - ONE_C;

    always_comb
    begin
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        addr             = lower_count_reg[AW-1:0];
        ctl.use_mem      = 1'b0;
        ctl.status       = ST_OK;
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        case (action)
            ACT_PUSH:
            begin
                if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else if (stack_select)
                begin
                    wr_en            = accept;
                    addr             = upper_push[AW-1:0];
                    upper_count_next = upper_count_reg + ONE_C;
                end
                else
                begin
                    wr_en            = accept;
                    addr             = lower_count_reg[AW-1:0];
                    lower_count_next = lower_count_reg + ONE_C;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (empty)
                begin
                    ctl.status = ST_EMPTY;
                end
                else
                begin
                    rd_en       = accept;
                    ctl.use_mem = 1'b1;
                    addr        = stack_select ? upper_top[AW-1:0] : lower_top[AW-1:0];
                    if (action == ACT_POP)
                    begin
                        if (stack_select)
                            upper_count_next = upper_count_reg - ONE_C;
                        else
                            lower_count_next = lower_count_reg - ONE_C;
                    end
                end
            end
            default:
            begin
                ctl.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else if (accept)
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

    // The two stacks never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        total <= {1'b0, DEPTH_C})
        else $error("stack counts exceed array depth");

    // A successful lower pop shrinks the lower stack by one
    a_lower_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == ACT_POP && !stack_select && lower_count_reg != '0
        |=> lower_count_reg == $past(lower_count_reg) - ONE_C)
        else $error("lower pop did not decrement count");

    // Single array port: a beat never both writes and reads
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("array written and read in the same cycle");

endmodule

>>> rtl/dual_stack_shared_memory.sv
// Two stacks sharing one array of DEPTH 32-bit words. The lower stack
// grows upward from entry 0, the upper stack downward from DEPTH-1.
//
// Input channel (in_valid/in_ready): one beat carries action (push, pop,
// peek), stack_select and push_value. Output channel (out_valid/
// out_ready): one beat per input beat, read_value and status, in order.
//
// A result's path: the synchronous array read and the result control
// land in the pending stage when its input beat is accepted, and the
// output register loads from the pending stage once it is free.
// Throughput: one beat per cycle while the output drains; every beat
// passes one pending stage ahead of the output register, and the array
// port is used at most once per beat.
//
// A push writes the array in its accept cycle; a pop/peek reads it in
// its accept cycle, so a later beat always sees earlier writes.
// When out_ready is low the output register holds its beat, the pending
// stage still fills, and in_ready drops only once both are occupied.
// Reset empties both stacks and clears the valid flags; array contents
// are not cleared and are never read before written.
module dual_stack_shared_memory #(
    parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         action,
    input  logic                               stack_select,
    input  logic signed [dss_pkg::DATA_W-1:0]  push_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [dss_pkg::DATA_W-1:0]  read_value,
    output logic [1:0]                         status
);
    import dss_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     addr;
    dss_ctl_t          ctl;

    // shared stack array, one port: at most one write or read per beat
    logic [DATA_W-1:0] stack_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // pending stage: beat waiting for the array read data
    logic              pend_valid_reg, pend_valid_next;
    dss_ctl_t          pend_ctl_reg;
    logic              pend_move;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [1:0]        status_reg;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pend_move = pend_valid_reg && out_free;
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;

    dss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .stack_select (stack_select),
        .wr_en        (wr_en),
        .rd_en        (rd_en),
        .addr         (addr),
        .ctl          (ctl)
    );

    // Read data register only loads on a read, so it holds while the
    // pending beat waits for the output register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[addr] <= push_value;
        if (rd_en)
            rdata_reg <= stack_mem[addr];
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
            pend_valid_next = 1'b1;
        else if (pend_move)
            pend_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pend_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_ctl_reg <= ctl;
        if (pend_move)
        begin
            status_reg <= pend_ctl_reg.status;
            if (pend_ctl_reg.use_mem)
                read_value_reg <= rdata_reg;
            else if (pend_ctl_reg.status == ST_EMPTY)
                read_value_reg <= '1;
            else
                read_value_reg <= '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // A pending beat is never dropped while the output is blocked
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !out_free |=> pend_valid_reg)
        else $error("pending beat lost under stall");

    // Accepted beat reaches the pending stage
    a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted beat not pending");

    // Empty status always carries all ones
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_EMPTY |-> read_value_reg == '1)
        else $error("empty result without all-ones value");

endmodule

>>> tb/dss_checker.sv
module dss_checker #(
    parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [1:0]                         action,
    input  logic                               stack_select,
    input  logic signed [dss_pkg::DATA_W-1:0]  push_value,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [dss_pkg::DATA_W-1:0]  read_value,
    input  logic [1:0]                         status,
    output int                                 outstanding,
    output int                                 errors
);
    import dss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } stack_result_t;

    // shadow copy of the shared array and both fill levels
    logic [DATA_W-1:0] words [DEPTH];
    int                lower_fill;
    int                upper_fill;

    stack_result_t     result_q [$];
    int                queued    = 0;
    int                err_count = 0;
    int                result_no = 0;

    assign outstanding = queued;
    assign errors      = err_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $time, result_no, what);
        err_count++;
    endtask

    // Applies one operation to the shadow stacks, returns the expected beat.
    function automatic stack_result_t apply_op(input logic [1:0] act, input logic sel,
                                               input logic [DATA_W-1:0] val);
        stack_result_t r;
        int            fill;
        int            slot;
        r.value  = '0;
        r.status = ST_OK;
        fill     = sel ? upper_fill : lower_fill;
        case (act)
            ACT_PUSH:
            begin
                if (lower_fill + upper_fill >= DEPTH)
                    r.status = ST_FULL;
                else if (!sel)
                begin
                    words[lower_fill] = val;
                    lower_fill++;
                end
                else
                begin
                    upper_fill++;
                    words[DEPTH - upper_fill] = val;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (fill == 0)
                begin
                    r.value  = '1;
                    r.status = ST_EMPTY;
                end
                else
                begin
                    slot    = sel ? DEPTH - upper_fill : lower_fill - 1;
                    r.value = words[slot];
                    if (act == ACT_POP)
                    begin
                        if (sel)
                            upper_fill--;
                        else
                            lower_fill--;
                    end
                end
            end
            default: ;  // unused code: no effect, ok status
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t got;
        stack_result_t want;
        if (!rst_n)
        begin
            lower_fill = 0;
            upper_fill = 0;
            result_q.delete();
            queued = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.value  = read_value;
                got.status = status;
                if (result_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = result_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("read_value %0d, expected %0d",
                                                  got.value, want.value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                end
                result_no++;
            end
            if (in_valid && in_ready)
                result_q.push_back(apply_op(action, stack_select, push_value));
            queued = result_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import dss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_OPS   = 650;
    localparam int STEADY_FROM  = 150;      // no idling on either side in this window
    localparam int STEADY_TO    = 300;
    localparam int HOLD_AT      = 350;      // sender waits for a full drain here
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // action code the block must ignore; the package gives it no name
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic [1:0]               action       = ACT_PUSH;
    logic                     stack_select = 1'b0;
    logic signed [DATA_W-1:0] push_value   = '0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;

    logic                     steady       = 1'b0;
    int                       outstanding;
    int                       errors;
    int                       cycles       = 0;

    always #2 clk = ~clk;

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .stack_select (stack_select),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status)
    );

    dss_checker #(
        .DEPTH(DEPTH)
    ) stack_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .stack_select (stack_select),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    // Receiver: stalls about a third of the cycles, never during the steady window.
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 32);

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Drives one input beat and returns at the edge where it is accepted.
    // A beat that follows with no gap is set up in that same step, so valid
    // stays high across back-to-back beats.
    task automatic send_op(input logic [1:0] act, input logic sel,
                           input logic signed [DATA_W-1:0] val);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 32)
                gap++;
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        stack_select <= sel;
        push_value   <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender goes quiet until every result in flight has come back.
    // It first waits for a clock edge, so the checker has counted the last accepted beat.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Push data: extremes often, otherwise anything.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int         sent;
        int         burst;
        int         push_pct;
        int         lean;
        int         roll;
        logic [1:0] act;
        logic       sel;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // pop and peek on both empty stacks
        send_op(ACT_PEEK, 1'b0, '0);
        send_op(ACT_POP,  1'b0, '0);
        send_op(ACT_PEEK, 1'b1, '0);
        send_op(ACT_POP,  1'b1, '0);
        // unused code on both stacks, payload must be ignored
        send_op(ACT_UNUSED, 1'b0, 32'hFFFF_FFFF);
        send_op(ACT_UNUSED, 1'b1, 32'h8000_0000);
        // extreme values, then peeks see them on top
        send_op(ACT_PUSH, 1'b0, 32'h7FFF_FFFF);
        send_op(ACT_PUSH, 1'b1, 32'h8000_0000);
        send_op(ACT_PEEK, 1'b0, '0);
        send_op(ACT_PEEK, 1'b1, '0);
        // fill until the two stacks meet
        for (int i = 0; i < DEPTH - 2; i++)
            send_op(ACT_PUSH, i[0], (i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
        // full: refused whichever stack is named
        send_op(ACT_PUSH, 1'b0, 32'h1234_5678);
        send_op(ACT_PUSH, 1'b1, 32'h8765_4321);
        // free one slot from the lower side, take it from the upper side
        send_op(ACT_POP,  1'b0, '0);
        send_op(ACT_PUSH, 1'b1, 32'h5A5A_A5A5);
        send_op(ACT_POP,  1'b1, '0);

        // --- random ---
        // Bursts lean toward filling, draining, or a mix, so both the full and the
        // empty boundaries are hit over and over with random content.
        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            burst = $urandom_range(4, 40);
            case ($urandom_range(2))
                0:       push_pct = 75;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            lean = $urandom_range(2);   // favor one stack, or none
            for (int k = 0; k < burst && sent < RANDOM_OPS; k++)
            begin
                steady <= (sent >= STEADY_FROM && sent < STEADY_TO);
                if (sent == HOLD_AT)
                    hold_until_drained();
                roll = $urandom_range(99);
                if (roll < 3)
                    act = ACT_UNUSED;
                else if ($urandom_range(99) < push_pct)
                    act = ACT_PUSH;
                else
                    act = ($urandom_range(99) < 70) ? ACT_POP : ACT_PEEK;
                if (lean == 2)
                    sel = $urandom_range(1);
                else
                    sel = ($urandom_range(99) < 85) ? lean[0] : !lean[0];
                send_op(act, sel, pick_word());
                sent++;
            end
        end

        // --- wind down ---
        in_valid <= 1'b0;
        steady   <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/dss_pkg.sv
rtl/dss_ctrl.sv
rtl/dual_stack_shared_memory.sv
tb/dss_checker.sv
tb/tb_top.sv
